[rtl/u8sd_pkg.sv]
// Package with the constants, types and byte decoding functions of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int LONGEST_SEQUENCE = 6;
    localparam int CP_WIDTH         = 31;
    localparam int BYTE_WIDTH       = 8;
    localparam int LEN_WIDTH        = 3;
    localparam int CONT_BITS        = 6;

    localparam logic [LEN_WIDTH-1:0] MAX_SEQ_RESET = 3'd6;

    typedef logic [LEN_WIDTH-1:0]  seq_len_t;
    typedef logic [CP_WIDTH-1:0]   code_point_t;
    typedef logic [BYTE_WIDTH-1:0] byte_t;

    // Sequence length announced by a lead byte; zero marks a byte that cannot lead.
    function automatic seq_len_t lead_length(input byte_t b);
        seq_len_t n;
        n = 3'd0;
        unique case (b) inside
            8'b0???????: n = 3'd1;
            8'b10??????: n = 3'd0;
            8'b110?????: n = 3'd2;
            8'b1110????: n = 3'd3;
            8'b11110???: n = 3'd4;
            8'b111110??: n = 3'd5;
            8'b1111110?: n = 3'd6;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // Payload bits of a lead byte for a sequence of the given length.
    function automatic byte_t lead_mask(input seq_len_t n);
        byte_t m;
        m = 8'h00;
        unique case (n)
            3'd1:    m = 8'h7F;
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'h0F;
            3'd4:    m = 8'h07;
            3'd5:    m = 8'h03;
            3'd6:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[rtl/utf8_stream_decoder_core.sv]
// Top level of the UTF-8 stream decoder: byte register, decode logic and result register.
`timescale 1ns / 1ps

// The decoder takes one byte per clock cycle and sustains that rate indefinitely while results
// are taken. A transferred byte is held in the byte register, is decoded by a single pass of
// logic against the sequence state, and a result, when the byte completes or breaks a sequence
// or cannot lead one, is then written into the result register.
// A byte that produces no result never waits for the output side; a byte that produces one
// waits only while the result register is full and not being taken. The longest sequence
// register resets to six and may only be written while no byte is in flight.
module utf8_stream_decoder_core
    import u8sd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [30:0]          code_point,
    output logic [2:0]           seq_length,
    output logic                 error,
    input  logic                 cfg_write_en,
    input  logic [2:0]           cfg_write_data
);

    seq_len_t    max_seq_reg;
    logic        byte_valid_reg, byte_valid_next;
    byte_t       byte_reg;
    seq_len_t    bytes_left_reg, bytes_left_next;
    seq_len_t    seq_len_reg, seq_len_next;
    code_point_t accum_reg, accum_next;
    logic        out_valid_reg, out_valid_next;
    code_point_t code_point_reg, code_point_next;
    seq_len_t    seq_length_reg, seq_length_next;
    logic        error_reg, error_next;

    seq_len_t    lead_len;
    code_point_t accum_shift;
    seq_len_t    left_dec;
    logic        emit;
    code_point_t emit_cp;
    seq_len_t    emit_len;
    logic        emit_err;
    logic        fire;

    assign lead_len    = lead_length(byte_reg);
    assign accum_shift = {accum_reg[CP_WIDTH-CONT_BITS-1:0], byte_reg[CONT_BITS-1:0]};
    assign left_dec    = bytes_left_reg - 3'd1;

    always_comb
    begin
        emit            = 1'b0;
        emit_cp         = '0;
        emit_len        = '0;
        emit_err        = 1'b0;
        bytes_left_next = bytes_left_reg;
        seq_len_next    = seq_len_reg;
        accum_next      = accum_reg;
        if (bytes_left_reg != 3'd0)
        begin
            if (byte_reg[7:6] != 2'b10)
            begin
                emit     = 1'b1;
                emit_err = 1'b1;
            end
            else
            begin
                accum_next      = accum_shift;
                bytes_left_next = left_dec;
                if (left_dec == 3'd0)
                begin
                    emit     = 1'b1;
                    emit_cp  = accum_shift;
                    emit_len = seq_len_reg;
                end
            end
        end
        else
        begin
            if (lead_len == 3'd0 || 32'(lead_len) > LONGEST_SEQUENCE || lead_len > max_seq_reg)
            begin
                emit     = 1'b1;
                emit_err = 1'b1;
            end
            else if (lead_len == 3'd1)
            begin
                emit     = 1'b1;
                emit_cp  = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, byte_reg & lead_mask(lead_len)};
                emit_len = 3'd1;
            end
            else
            begin
                accum_next      = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, byte_reg & lead_mask(lead_len)};
                seq_len_next    = lead_len;
                bytes_left_next = lead_len - 3'd1;
            end
        end
        if (emit)
        begin
            bytes_left_next = '0;
            seq_len_next    = '0;
            accum_next      = '0;
        end
    end

    assign fire     = byte_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || fire;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_valid && in_ready)
        begin
            byte_valid_next = 1'b1;
        end
        else if (fire)
        begin
            byte_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        code_point_next = code_point_reg;
        seq_length_next = seq_length_reg;
        error_next      = error_reg;
        if (fire && emit)
        begin
            out_valid_next  = 1'b1;
            code_point_next = emit_cp;
            seq_length_next = emit_len;
            error_next      = emit_err;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seq_reg    <= MAX_SEQ_RESET;
            byte_valid_reg <= 1'b0;
            bytes_left_reg <= '0;
            seq_len_reg    <= '0;
            accum_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_seq_reg <= cfg_write_data;
            end
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
            if (fire)
            begin
                bytes_left_reg <= bytes_left_next;
                seq_len_reg    <= seq_len_next;
                accum_reg      <= accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
        code_point_reg <= code_point_next;
        seq_length_reg <= seq_length_next;
        error_reg      <= error_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign seq_length = seq_length_reg;
    assign error      = error_reg;

    // An error result carries neither a code point nor a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> code_point_reg == '0 && seq_length_reg == '0)
        else $error("error result with non-zero payload");

    // A successful result always names a length within the supported range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !error_reg |-> seq_length_reg != 3'd0 && seq_length_reg <= 3'd6)
        else $error("successful result with bad length");

    // The count of expected continuation bytes stays below the longest sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(bytes_left_reg) < LONGEST_SEQUENCE && bytes_left_reg < seq_len_reg
        || bytes_left_reg == 3'd0)
        else $error("continuation count out of range");

    // Every emitted result leaves the sequence state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> bytes_left_reg == 3'd0 && seq_len_reg == 3'd0 && out_valid_reg)
        else $error("state not cleared after a result");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;
    import u8sd_pkg::*;

    typedef struct packed {
        code_point_t cp;
        seq_len_t    len;
        logic        err;
    } decoded_char_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [30:0] code_point;
    logic [2:0]  seq_length;
    logic        error;
    logic        cfg_write_en;
    logic [2:0]  cfg_write_data;

    decoded_char_t expected_chars[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    seq_len_t    max_len;
    seq_len_t    bytes_owed;
    seq_len_t    char_len;
    code_point_t partial_cp;

    utf8_stream_decoder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .code_point     (code_point),
        .seq_length     (seq_length),
        .error          (error),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_char();
        bytes_owed = '0;
        char_len   = '0;
        partial_cp = '0;
    endfunction

    function automatic void decode_byte(input byte_t b, output bit produced,
                                        output decoded_char_t res);
        int ones;
        int n;
        int i;
        produced = 1'b0;
        res      = '{cp: '0, len: '0, err: 1'b1};
        if (bytes_owed != 0)
        begin
            if (b[7:6] != 2'b10)
            begin
                produced = 1'b1;
                clear_char();
            end
            else
            begin
                partial_cp = {partial_cp[24:0], b[5:0]};
                bytes_owed = bytes_owed - 3'd1;
                if (bytes_owed == 0)
                begin
                    produced = 1'b1;
                    res      = '{cp: partial_cp, len: char_len, err: 1'b0};
                    clear_char();
                end
            end
        end
        else
        begin
            ones = 0;
            i = 7;
            while (i >= 0 && b[i])
            begin
                ones++;
                i--;
            end
            if (ones == 0)
                n = 1;
            else if (ones == 1 || ones > LONGEST_SEQUENCE)
                n = 0;
            else
                n = ones;
            if (n == 0 || n > int'(max_len))
            begin
                produced = 1'b1;
            end
            else if (n == 1)
            begin
                produced = 1'b1;
                res      = '{cp: code_point_t'(b), len: 3'd1, err: 1'b0};
            end
            else
            begin
                partial_cp = code_point_t'(b & (8'hFF >> (n + 1)));
                char_len   = seq_len_t'(n);
                bytes_owed = seq_len_t'(n - 1);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        decoded_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected result", {1'b0, code_point}, 0);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (code_point !== want.cp)
                    report_mismatch("code_point", {1'b0, code_point}, {1'b0, want.cp});
                if (seq_length !== want.len)
                    report_mismatch("seq_length", int'(seq_length), int'(want.len));
                if (error !== want.err)
                    report_mismatch("error", int'(error), int'(want.err));
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic push_byte(input byte_t b);
        bit            produced;
        decoded_char_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_byte  <= byte_t'($urandom);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b, produced, res);
        if (produced)
            expected_chars.push_back(res);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max_len(input seq_len_t value);
        wait_idle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        max_len = value;
    endtask

    function automatic byte_t make_lead(input int n);
        if (n == 1)
            return byte_t'($urandom) & 8'h7F;
        return (8'hFF << (8 - n)) | (byte_t'($urandom) & (8'hFF >> (n + 1)));
    endfunction

    task automatic send_char(input int n);
        push_byte(make_lead(n));
        repeat (n - 1) push_byte(8'h80 | (byte_t'($urandom) & 8'h3F));
    endtask

    // A sequence cut short by a byte that is not a continuation.
    task automatic send_broken_char();
        int    n;
        byte_t breaker;
        n = $urandom_range(2, 6);
        push_byte(make_lead(n));
        repeat ($urandom_range(0, n - 2)) push_byte(8'h80 | (byte_t'($urandom) & 8'h3F));
        breaker = byte_t'($urandom);
        if (breaker[7:6] == 2'b10)
            breaker[6] = 1'b1;
        push_byte(breaker);
    endtask

    task automatic test_single_byte();
        push_byte(8'h00);
        push_byte(8'h7F);
    endtask

    task automatic test_multi_byte();
        push_byte(8'hDF);
        push_byte(8'hBF);
        push_byte(8'hC2);
        push_byte(8'hA9);
        push_byte(8'hFD);
        repeat (5) push_byte(8'hBF);
    endtask

    task automatic test_bad_lead();
        push_byte(8'h80);
        push_byte(8'hFE);
        push_byte(8'hFF);
    endtask

    task automatic test_broken_sequence();
        push_byte(8'hC3);
        push_byte(8'h41);
    endtask

    task automatic test_length_limit();
        write_max_len(3'd0);
        push_byte(8'h41);
        write_max_len(3'd1);
        push_byte(8'h41);
        push_byte(8'hC2);
        write_max_len(3'd7);
        push_byte(8'hFC);
        repeat (4) push_byte(8'h80);
        push_byte(8'h81);
        write_max_len(3'd6);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_count);
        int sent;
        int start;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_count)
        begin
            if (sent != 0 && $urandom_range(0, 99) < 2)
                write_max_len(seq_len_t'($urandom_range(1, 7)));
            start = sent;
            pick  = $urandom_range(0, 99);
            if (pick < 80)
            begin
                pick = $urandom_range(1, 6);
                send_char(pick);
                sent += pick;
            end
            else if (pick < 90)
            begin
                send_broken_char();
                sent += 3;
            end
            else
            begin
                push_byte(byte_t'($urandom));
                sent++;
            end
            if (sent == start)
                sent++;
        end
        write_max_len(seq_len_t'($urandom_range(1, 7)));
    endtask

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = '0;
        out_ready      = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        mismatch_count = 0;
        send_idle_pct  = 38;
        recv_idle_pct  = 55;
        max_len        = MAX_SEQ_RESET;
        clear_char();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_byte();
        test_multi_byte();
        test_bad_lead();
        test_broken_sequence();
        test_length_limit();
        test_random_traffic(38, 55, 180);
        test_random_traffic(55, 38, 180);
        test_random_traffic(0, 0, 180);

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/u8sd_pkg.sv
rtl/utf8_stream_decoder_core.sv
verif/testbench.sv
